FILE: src/prtc_pkg.sv
// ----------------------------------------------------------------------------
// Pulse rate meter package
// Shared widths, reset values, register indexes and types of the pulse rate
// meter.
// ----------------------------------------------------------------------------
package prtc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int RATE_W     = 19;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam int HISTORY_DEPTH_DEFAULT = 8;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2100;
    localparam logic [RATE_W-1:0]   NUMERATOR_RESET = 19'd300000;
    localparam logic [COUNT_W-1:0]  TIMEOUT_RESET   = 16'd1000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX       = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    typedef struct packed {
        logic               beat;
        logic               timed;
        logic [COUNT_W-1:0] divisor;
    } cmd_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV_RATE,
        BACK_DIV_AVG,
        BACK_EMIT
    } back_state_t;

endpackage

FILE: src/prtc_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one converter sample per transaction.
// ----------------------------------------------------------------------------
interface prtc_sample_if;
    logic                          valid;
    logic                          ready;
    logic [prtc_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

FILE: src/prtc_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one rate result per transaction.
// ----------------------------------------------------------------------------
interface prtc_result_if;
    logic                        valid;
    logic                        ready;
    logic [prtc_pkg::RATE_W-1:0] instant_rate;
    logic [prtc_pkg::RATE_W-1:0] average_rate;
    logic                        beat_detected;
    logic                        timed_out;

    modport source (output valid, output instant_rate, output average_rate,
                    output beat_detected, output timed_out, input ready);
    modport sink (input valid, input instant_rate, input average_rate,
                  input beat_detected, input timed_out, output ready);
endinterface

FILE: src/prtc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module prtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/prtc_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prtc_div #(
    parameter int DW = 22,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        fits      = trial >= {1'b0, dvs_reg};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/prtc_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts samples, detects rising crossings and timeouts, keeps the interval
// count and queues one command per sample.
// ----------------------------------------------------------------------------
module prtc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    prtc_sample_if.sink                    samples,
    input  logic [prtc_pkg::SAMPLE_W-1:0]  threshold,
    input  logic [prtc_pkg::COUNT_W-1:0]   timeout_count,
    input  logic                           full,
    output logic                           push,
    output prtc_pkg::cmd_t                 cmd
);

    logic [prtc_pkg::SAMPLE_W-1:0] prev_reg, prev_next;
    logic [prtc_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [prtc_pkg::COUNT_W-1:0]  count_base;
    logic                          beat;
    logic                          timed;

    always_comb
    begin
        timed = count_reg >= timeout_count;
        beat  = (prev_reg < threshold) && (samples.sample > threshold);

        cmd.beat    = beat;
        cmd.timed   = timed;
        cmd.divisor = (count_reg == '0) ? prtc_pkg::COUNT_W'(1) : count_reg;

        samples.ready = !full;
        push          = samples.valid && !full;

        count_base = beat ? '0 : count_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        if (push)
        begin
            prev_next  = samples.sample;
            count_next = (count_base != prtc_pkg::COUNT_MAX) ? count_base + 1'b1 : count_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/prtc_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module prtc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  prtc_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output prtc_pkg::cmd_t pop_data,
    output logic           not_empty
);

    localparam int PW = $clog2(prtc_pkg::QUEUE_DEPTH);
    localparam int FW = $clog2(prtc_pkg::QUEUE_DEPTH + 1);

    prtc_pkg::cmd_t entry_reg [prtc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [FW-1:0]  fill_reg, fill_next;

    always_comb
    begin
        full      = fill_reg == FW'(prtc_pkg::QUEUE_DEPTH);
        not_empty = fill_reg != '0;
        pop_data  = entry_reg[rptr_reg];
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(prtc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(prtc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/prtc_back.sv
// ----------------------------------------------------------------------------
// Back end
// Computes the rate for each beat, maintains the history ring and its running
// sum, scales the sum for the average and presents the result.
// ----------------------------------------------------------------------------
module prtc_back #(
    parameter int HISTORY_DEPTH = prtc_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  prtc_pkg::cmd_t               cmd,
    output logic                         pop,
    input  logic [prtc_pkg::RATE_W-1:0]  rate_numerator,
    prtc_result_if.source                results
);

    localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
    localparam int SUM_W     = prtc_pkg::RATE_W + SLOT_W;
    localparam int AVG_SHIFT = SUM_W + SLOT_W;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    // The rounded-up reciprocal gives the exact floor for every sum that fits in SUM_W bits.
    localparam longint AVG_SCALE = ((longint'(1) << AVG_SHIFT) + longint'(HISTORY_DEPTH) - 1)
                                   / longint'(HISTORY_DEPTH);
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_SCALE);

    prtc_pkg::back_state_t         state_reg, state_next;
    logic                          beat_reg, beat_next;
    logic                          timed_reg, timed_next;
    logic [prtc_pkg::RATE_W-1:0]   rate_reg, rate_next;
    logic [prtc_pkg::RATE_W-1:0]   avg_reg, avg_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [SLOT_W-1:0]             slot_reg, slot_next;
    logic [HISTORY_DEPTH-1:0]      valid_reg, valid_next;
    logic                          old_valid_reg, old_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic [prtc_pkg::RATE_W-1:0]   out_rate_reg, out_rate_next;
    logic [prtc_pkg::RATE_W-1:0]   out_avg_reg, out_avg_next;
    logic                          out_beat_reg, out_beat_next;
    logic                          out_timed_reg, out_timed_next;

    logic                          div_start;
    logic [prtc_pkg::RATE_W-1:0]   div_dividend;
    logic [prtc_pkg::COUNT_W-1:0]  div_divisor;
    logic                          div_done;
    logic [prtc_pkg::RATE_W-1:0]   div_quotient;

    logic                          ram_we;
    logic                          ram_re;
    logic [prtc_pkg::RATE_W-1:0]   ram_rdata;
    logic [prtc_pkg::RATE_W-1:0]   old_rate;
    logic [prtc_pkg::RATE_W-1:0]   new_rate;
    logic [SUM_W-1:0]              sum_new;
    logic [PROD_W-1:0]             avg_product;

    prtc_div #(
        .DW (prtc_pkg::RATE_W),
        .VW (prtc_pkg::COUNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    prtc_ram #(
        .WIDTH (prtc_pkg::RATE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (new_rate),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        old_rate    = old_valid_reg ? ram_rdata : '0;
        new_rate    = div_quotient;
        sum_new     = sum_reg - SUM_W'(old_rate) + SUM_W'(new_rate);
        avg_product = PROD_W'(sum_reg) * PROD_W'(AVG_RECIP);

        state_next     = state_reg;
        beat_next      = beat_reg;
        timed_next     = timed_reg;
        rate_next      = rate_reg;
        avg_next       = avg_reg;
        sum_next       = sum_reg;
        slot_next      = slot_reg;
        valid_next     = valid_reg;
        old_valid_next = old_valid_reg;
        out_rate_next  = out_rate_reg;
        out_avg_next   = out_avg_reg;
        out_beat_next  = out_beat_reg;
        out_timed_next = out_timed_reg;
        out_valid_next = out_valid_reg && !results.ready;

        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        div_start    = 1'b0;
        div_dividend = rate_numerator;
        div_divisor  = cmd.divisor;

        unique case (state_reg)
            prtc_pkg::BACK_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop        = 1'b1;
                    beat_next  = cmd.beat;
                    timed_next = cmd.timed;
                    if (cmd.timed)
                    begin
                        rate_next = '0;
                    end
                    if (cmd.beat)
                    begin
                        ram_re         = 1'b1;
                        old_valid_next = valid_reg[slot_reg];
                        div_start      = 1'b1;
                        state_next     = prtc_pkg::BACK_DIV_RATE;
                    end
                    else
                    begin
                        state_next = prtc_pkg::BACK_EMIT;
                    end
                end
            end
            prtc_pkg::BACK_DIV_RATE:
            begin
                if (div_done)
                begin
                    rate_next            = new_rate;
                    sum_next             = sum_new;
                    ram_we               = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                         : slot_reg + 1'b1;
                    state_next   = prtc_pkg::BACK_DIV_AVG;
                end
            end
            prtc_pkg::BACK_DIV_AVG:
            begin
                avg_next   = avg_product[AVG_SHIFT +: prtc_pkg::RATE_W];
                state_next = prtc_pkg::BACK_EMIT;
            end
            prtc_pkg::BACK_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = rate_reg;
                    out_avg_next   = avg_reg;
                    out_beat_next  = beat_reg;
                    out_timed_next = timed_reg;
                    state_next     = prtc_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = prtc_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prtc_pkg::BACK_IDLE;
            rate_reg      <= '0;
            avg_reg       <= '0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            avg_reg       <= avg_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            valid_reg     <= valid_next;
            old_valid_reg <= old_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg      <= beat_next;
        timed_reg     <= timed_next;
        out_rate_reg  <= out_rate_next;
        out_avg_reg   <= out_avg_next;
        out_beat_reg  <= out_beat_next;
        out_timed_reg <= out_timed_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.instant_rate  = out_rate_reg;
    assign results.average_rate  = out_avg_reg;
    assign results.beat_detected = out_beat_reg;
    assign results.timed_out     = out_timed_reg;

endmodule

FILE: src/pulse_rate_from_threshold_crossing_top.sv
// ----------------------------------------------------------------------------
// Pulse rate meter
// Measures heart rate from rising threshold crossings of a pulse-sensor signal.
// ----------------------------------------------------------------------------
// The samples channel takes one 12-bit converter sample per transaction, and
// the results channel returns exactly one result per sample, in order: the
// instantaneous rate, the average over the history ring, a beat flag and a
// timeout flag. Registers are written through cfg_we, cfg_index and cfg_wdata;
// the user must write them only while the block is idle, as the block itself
// does not enforce this; indexes past the last register are ignored.
// A sample without a beat passes through the idle and emit states of the back
// end into the output register. A beat runs the serial divider for the rate,
// one quotient bit per cycle over the 19 bits of the numerator, and takes the
// average of the history by a reciprocal multiplication in the average state
// before the emit state. The two-entry command queue lets the front end keep
// accepting samples while the divider works.
// Reset clears the interval count, the previous sample, the rates, the history
// ring and the registers to their default values. When the receiver stalls,
// the result is held in the output register, the back end stops once the next
// result is ready, and samples are refused once the queue is full.
// ----------------------------------------------------------------------------
module pulse_rate_from_threshold_crossing_top #(
    parameter int HISTORY_DEPTH = prtc_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [prtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prtc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    prtc_sample_if.sink                      samples,
    prtc_result_if.source                    results
);

    logic [prtc_pkg::SAMPLE_W-1:0] threshold_reg, threshold_next;
    logic [prtc_pkg::RATE_W-1:0]   numerator_reg, numerator_next;
    logic [prtc_pkg::COUNT_W-1:0]  timeout_reg, timeout_next;

    logic           push;
    logic           full;
    logic           pop;
    logic           not_empty;
    prtc_pkg::cmd_t front_cmd;
    prtc_pkg::cmd_t back_cmd;

    always_comb
    begin
        threshold_next = threshold_reg;
        numerator_next = numerator_reg;
        timeout_next   = timeout_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                prtc_pkg::CFG_THRESHOLD: threshold_next = cfg_wdata[prtc_pkg::SAMPLE_W-1:0];
                prtc_pkg::CFG_NUMERATOR: numerator_next = cfg_wdata[prtc_pkg::RATE_W-1:0];
                prtc_pkg::CFG_TIMEOUT:   timeout_next   = cfg_wdata[prtc_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= prtc_pkg::THRESHOLD_RESET;
            numerator_reg <= prtc_pkg::NUMERATOR_RESET;
            timeout_reg   <= prtc_pkg::TIMEOUT_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
            numerator_reg <= numerator_next;
            timeout_reg   <= timeout_next;
        end
    end

    prtc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .threshold     (threshold_reg),
        .timeout_count (timeout_reg),
        .full          (full),
        .push          (push),
        .cmd           (front_cmd)
    );

    prtc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (back_cmd),
        .not_empty (not_empty)
    );

    prtc_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (not_empty),
        .cmd            (back_cmd),
        .pop            (pop),
        .rate_numerator (numerator_reg),
        .results        (results)
    );

endmodule
